/* rtl/mono_bitmap_blit_engine_assert.svh */
`ifndef MONO_BITMAP_BLIT_ENGINE_ASSERT_SVH
`define MONO_BITMAP_BLIT_ENGINE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define MBB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define MBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mbb_pkg.sv */
package mbb_pkg;

  localparam int unsigned MaxWidthDef   = 64;
  localparam int unsigned MaxHeightDef  = 64;
  localparam int unsigned NumBitmapsDef = 4;

  localparam int unsigned OpW     = 3;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned PosW    = 6;
  localparam int unsigned SizeW   = 7;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgRegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRegHeight = 1'b1;
  localparam logic [SizeW-1:0]   SizeResetVal = 7'd64;

  typedef enum logic [OpW-1:0] {
    OpWritePix = 3'd0,
    OpReadPix  = 3'd1,
    OpCopy     = 3'd2,
    OpMirCol   = 3'd3,
    OpMirRow   = 3'd4,
    OpRotate   = 3'd5,
    OpOr       = 3'd6,
    OpXor      = 3'd7
  } op_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // latch the command fields
    logic check;       // capture bounds status, clear read value
    logic wr_pixel;    // single-pixel write
    logic rd_capture;  // take the read pixel from the read port
    logic issue;       // walk one pixel or row
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic err;
    logic is_write;
    logic is_read;
    logic empty;
    logic walk_last;
  } dp_stat_t;

endpackage

/* rtl/mbb_mem.sv */
module mbb_mem
  import mbb_pkg::*;
#(
  parameter int unsigned DW    = MaxWidthDef,
  parameter int unsigned DEPTH = NumBitmapsDef * MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wmask_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [DW-1:0]            rdata_a_o,
  output logic [DW-1:0]            rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_a_q, rd_b_q, wmask_q, wdata_q;
  logic          byp_a_q, byp_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int k = 0; k < DW; k++) begin
        if (wmask_i[k]) begin
          mem_q[waddr_i][k] <= wdata_i[k];
        end
      end
    end
    rd_a_q  <= mem_q[raddr_a_i];
    rd_b_q  <= mem_q[raddr_b_i];
    byp_a_q <= we_i && (waddr_i == raddr_a_i);
    byp_b_q <= we_i && (waddr_i == raddr_b_i);
    wmask_q <= wmask_i;
    wdata_q <= wdata_i;
  end

  // Merge a write that hit the same row in the read cycle.
  assign rdata_a_o = byp_a_q ? ((rd_a_q & ~wmask_q) | (wdata_q & wmask_q)) : rd_a_q;
  assign rdata_b_o = byp_b_q ? ((rd_b_q & ~wmask_q) | (wdata_q & wmask_q)) : rd_b_q;

endmodule

/* rtl/mbb_datapath.sv */
`include "mono_bitmap_blit_engine_assert.svh"

module mbb_datapath
  import mbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT  = MaxHeightDef,
  parameter int unsigned NUM_BITMAPS = NumBitmapsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_stat_t           stat_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_wdata_i,
  input  logic [OpW-1:0]     op_i,
  input  logic [IdxW-1:0]    src_index_i,
  input  logic [IdxW-1:0]    second_index_i,
  input  logic [IdxW-1:0]    dst_index_i,
  input  logic [PosW-1:0]    src_row_i,
  input  logic [PosW-1:0]    src_col_i,
  input  logic [PosW-1:0]    dst_row_i,
  input  logic [PosW-1:0]    dst_col_i,
  input  logic [SizeW-1:0]   rect_wid_i,
  input  logic [SizeW-1:0]   rect_hgt_i,
  input  logic               pixel_value_i,
  output logic               read_value_o,
  output logic               status_o
);

  localparam int unsigned Depth = NUM_BITMAPS * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam logic [MAX_WIDTH-1:0] OneBit = {{(MAX_WIDTH-1){1'b0}}, 1'b1};

  function automatic logic [AW-1:0] row_addr(input logic [IdxW-1:0]  b,
                                             input logic [SizeW-1:0] r);
    row_addr = AW'(32'(b) * MAX_HEIGHT) + AW'(r);
  endfunction

  // Size registers and their clamped values.
  logic [SizeW-1:0] width_q, height_q, used_w, used_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SizeResetVal;
      height_q <= SizeResetVal;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRegWidth:  width_q  <= cfg_wdata_i;
        CfgRegHeight: height_q <= cfg_wdata_i;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) used_w = SizeW'(1);
    else if (32'(width_q) > MAX_WIDTH) used_w = SizeW'(MAX_WIDTH);
    else used_w = width_q;
    if (height_q == '0) used_h = SizeW'(1);
    else if (32'(height_q) > MAX_HEIGHT) used_h = SizeW'(MAX_HEIGHT);
    else used_h = height_q;
  end

  // Latched command.
  op_e              op_q;
  logic [IdxW-1:0]  si_q, s2_q, di_q;
  logic [PosW-1:0]  sr_q, sc_q, dr_q, dc_q;
  logic [SizeW-1:0] w_q, h_q;
  logic             pv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_e'(op_i);
      si_q <= src_index_i;
      s2_q <= second_index_i;
      di_q <= dst_index_i;
      sr_q <= src_row_i;
      sc_q <= src_col_i;
      dr_q <= dst_row_i;
      dc_q <= dst_col_i;
      w_q  <= rect_wid_i;
      h_q  <= rect_hgt_i;
      pv_q <= pixel_value_i;
    end
  end

  // Bounds check.
  logic             si_bad, s2_bad, di_bad, err, is_rect, is_combine;
  logic [SizeW:0]   sc_end_w, dc_end_w, sr_end_h, dr_end_h, sr_end_w, dc_end_n, dr_end_n;
  logic [SizeW:0]   w_ext, h_ext;

  assign si_bad   = 32'(si_q) >= NUM_BITMAPS;
  assign s2_bad   = 32'(s2_q) >= NUM_BITMAPS;
  assign di_bad   = 32'(di_q) >= NUM_BITMAPS;
  assign w_ext    = {1'b0, used_w};
  assign h_ext    = {1'b0, used_h};
  assign sc_end_w = {2'b0, sc_q} + {1'b0, w_q};
  assign dc_end_w = {2'b0, dc_q} + {1'b0, w_q};
  assign sr_end_h = {2'b0, sr_q} + {1'b0, h_q};
  assign dr_end_h = {2'b0, dr_q} + {1'b0, h_q};
  assign sr_end_w = {2'b0, sr_q} + {1'b0, w_q};
  assign dc_end_n = dc_end_w;
  assign dr_end_n = {2'b0, dr_q} + {1'b0, w_q};

  always_comb begin
    unique case (op_q)
      OpWritePix: err = di_bad || ({1'b0, dr_q} >= used_h) || ({1'b0, dc_q} >= used_w);
      OpReadPix:  err = si_bad || ({1'b0, dr_q} >= used_h) || ({1'b0, dc_q} >= used_w);
      OpCopy, OpMirCol, OpMirRow:
        err = si_bad || di_bad || (sc_end_w > w_ext) || (dc_end_w > w_ext) ||
              (sr_end_h > h_ext) || (dr_end_h > h_ext);
      OpRotate:
        err = si_bad || di_bad || (sc_end_w > w_ext) || (sr_end_w > h_ext) ||
              (dc_end_n > h_ext) || (dr_end_n > w_ext);
      OpOr, OpXor: err = si_bad || s2_bad || di_bad;
    endcase
  end

  assign is_combine = (op_q == OpOr) || (op_q == OpXor);
  assign is_rect    = (op_q == OpCopy) || (op_q == OpMirCol) || (op_q == OpMirRow) ||
                      (op_q == OpRotate);

  // Walk limits: rows inner, columns outer; combine walks rows only.
  logic [SizeW-1:0] ilim, jlim, i_q, j_q;

  always_comb begin
    ilim = SizeW'(1);
    jlim = SizeW'(1);
    if (is_rect) begin
      ilim = (op_q == OpRotate) ? w_q : h_q;
      jlim = w_q;
    end else if (is_combine) begin
      ilim = used_h;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.load) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.issue) begin
      if (i_q == ilim - SizeW'(1)) begin
        i_q <= '0;
        j_q <= j_q + SizeW'(1);
      end else begin
        i_q <= i_q + SizeW'(1);
      end
    end
  end

  assign stat_o.err       = err;
  assign stat_o.is_write  = (op_q == OpWritePix);
  assign stat_o.is_read   = (op_q == OpReadPix);
  assign stat_o.empty     = is_rect && ((ilim == '0) || (jlim == '0));
  assign stat_o.walk_last = (i_q == ilim - SizeW'(1)) && (j_q == jlim - SizeW'(1));

  // Coordinates of the current walk step.
  logic [SizeW-1:0] rev_i, rev_j, sr_i, sc_j, sc_rev, dr_i, dr_rev, dc_j, dc_rev;
  logic [SizeW-1:0] src_row, src_col, dst_row, dst_col;

  assign rev_i  = h_q - SizeW'(1) - i_q;
  assign rev_j  = w_q - SizeW'(1) - j_q;
  assign sr_i   = SizeW'(sr_q) + i_q;
  assign sc_j   = SizeW'(sc_q) + j_q;
  assign sc_rev = SizeW'(sc_q) + rev_j;
  assign dr_i   = SizeW'(dr_q) + i_q;
  assign dr_rev = SizeW'(dr_q) + rev_i;
  assign dc_j   = SizeW'(dc_q) + j_q;
  assign dc_rev = SizeW'(dc_q) + rev_j;

  always_comb begin
    src_row = SizeW'(dr_q);
    src_col = SizeW'(dc_q);
    dst_row = SizeW'(dr_q);
    dst_col = SizeW'(dc_q);
    unique case (op_q)
      OpWritePix, OpReadPix: ;
      OpCopy: begin
        src_row = sr_i;   src_col = sc_j;
        dst_row = dr_i;   dst_col = dc_j;
      end
      OpMirCol: begin
        src_row = sr_i;   src_col = sc_j;
        dst_row = dr_i;   dst_col = dc_rev;
      end
      OpMirRow: begin
        src_row = sr_i;   src_col = sc_j;
        dst_row = dr_rev; dst_col = dc_j;
      end
      OpRotate: begin
        src_row = sr_i;   src_col = sc_rev;
        dst_row = dc_j;   dst_col = dr_i;
      end
      OpOr, OpXor: begin
        src_row = i_q;    src_col = '0;
        dst_row = i_q;    dst_col = '0;
      end
    endcase
  end

  // Write stage: one step behind the read.
  logic                 s1_valid_q;
  logic [AW-1:0]        s1_addr_q, dst_addr;
  logic [CW-1:0]        s1_scol_q, s1_dcol_q;
  logic [MAX_WIDTH-1:0] rd_a, rd_b, width_mask, combine_row;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [MAX_WIDTH-1:0] wmask, wdata;

  assign dst_addr = row_addr(di_q, dst_row);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= cmd_i.issue;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_addr_q <= dst_addr;
      s1_scol_q <= CW'(src_col);
      s1_dcol_q <= CW'(dst_col);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_WIDTH; k++) begin
      width_mask[k] = 32'(k) < 32'(used_w);
    end
  end

  assign combine_row = (op_q == OpXor) ? (rd_a ^ rd_b) : (rd_a | rd_b);

  always_comb begin
    we    = 1'b0;
    waddr = dst_addr;
    wmask = OneBit << CW'(dst_col);
    wdata = {MAX_WIDTH{pv_q}};
    if (s1_valid_q) begin
      we    = 1'b1;
      waddr = s1_addr_q;
      wmask = is_combine ? width_mask : (OneBit << s1_dcol_q);
      wdata = is_combine ? combine_row : {MAX_WIDTH{rd_a[s1_scol_q]}};
    end else if (cmd_i.wr_pixel) begin
      we = 1'b1;
    end
  end

  mbb_mem #(
    .DW    (MAX_WIDTH),
    .DEPTH (Depth)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wmask_i   (wmask),
    .wdata_i   (wdata),
    .raddr_a_i (row_addr(si_q, src_row)),
    .raddr_b_i (row_addr(s2_q, i_q)),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Result.
  logic read_value_q, status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      status_q     <= err;
      read_value_q <= 1'b0;
    end else if (cmd_i.rd_capture) begin
      read_value_q <= rd_a[CW'(dc_q)];
    end
  end

  assign read_value_o = read_value_q;
  assign status_o     = status_q;

  `MBB_ASSERT_IMPLY(a_port_free, clk_i, rst_ni, s1_valid_q, !cmd_i.wr_pixel,
                    "pixel write collides with walk write")
  `MBB_ASSERT_IMPLY(a_walk_clean, clk_i, rst_ni, cmd_i.issue, !err,
                    "walk step on a command that failed bounds")
  `MBB_ASSERT_IMPLY(a_walk_range, clk_i, rst_ni, cmd_i.issue, (i_q < ilim) && (j_q < jlim),
                    "walk counter past its limit")

endmodule

/* rtl/mbb_ctrl.sv */
`include "mono_bitmap_blit_engine_assert.svh"

module mbb_ctrl
  import mbb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StReadWait,
    StWalk,
    StDrain
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) state_q <= StCheck;
        end
        StCheck: begin
          priority if (stat_i.err || stat_i.is_write || stat_i.empty) begin
            state_q <= StIdle;
            done_q  <= 1'b1;
          end else if (stat_i.is_read) begin
            state_q <= StReadWait;
          end else begin
            state_q <= StWalk;
          end
        end
        StReadWait: begin
          state_q <= StIdle;
          done_q  <= 1'b1;
        end
        StWalk: begin
          if (stat_i.walk_last) state_q <= StDrain;
        end
        StDrain: begin
          state_q <= StIdle;
          done_q  <= 1'b1;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o.load       = start_i && (state_q == StIdle);
    cmd_o.check      = (state_q == StCheck);
    cmd_o.wr_pixel   = (state_q == StCheck) && !stat_i.err && stat_i.is_write;
    cmd_o.rd_capture = (state_q == StReadWait);
    cmd_o.issue      = (state_q == StWalk);
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

  `MBB_ASSERT_IMPLY(a_done_idle, clk_i, rst_ni, done_q, state_q == StIdle,
                    "result strobe while a command is running")
  `MBB_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q,
                   "result strobe longer than one cycle")
  `MBB_ASSERT_NEXT(a_walk_drain, clk_i, rst_ni, (state_q == StWalk) && stat_i.walk_last,
                   state_q == StDrain, "last walk step not followed by drain")

endmodule

/* rtl/mono_bitmap_blit_engine.sv */
// Channel   Direction  Handshake                  Payload
// command   in         start_i, busy_o            op_i .. pixel_value_i
// result    out        done_o (one-cycle strobe)  read_value_o, status_o
// config    in         cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_wdata_i
//
// An item is taken when start_i is high and busy_o low; its result shows for one
// cycle with done_o. A pixel write, an empty rectangle or a bounds error ends at
// the bounds check, a pixel read after a read wait; a walk covers w*h pixels for
// a copy or mirror, w*w for a rotate and H rows for an OR/XOR combine. The single
// bitmap write port sets the pace: one pixel (or one combined row) per cycle. Reset
// is asynchronous, active low, and clears control and size registers only; bitmap
// contents are undefined until written. The result side has no back-pressure, and
// a new item may be taken in the cycle its predecessor's result is shown.
module mono_bitmap_blit_engine
  import mbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT  = MaxHeightDef,
  parameter int unsigned NUM_BITMAPS = NumBitmapsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command
  input  logic               start_i,
  output logic               busy_o,
  input  logic [OpW-1:0]     op_i,
  input  logic [IdxW-1:0]    src_index_i,
  input  logic [IdxW-1:0]    second_index_i,
  input  logic [IdxW-1:0]    dst_index_i,
  input  logic [PosW-1:0]    src_row_i,
  input  logic [PosW-1:0]    src_col_i,
  input  logic [PosW-1:0]    dst_row_i,
  input  logic [PosW-1:0]    dst_col_i,
  input  logic [SizeW-1:0]   rect_wid_i,
  input  logic [SizeW-1:0]   rect_hgt_i,
  input  logic               pixel_value_i,
  // result
  output logic               done_o,
  output logic               read_value_o,
  output logic               status_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SizeW-1:0]   cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Size registers change only between items.
  assign cfg_ready_o = !busy_o;

  // Sequencer: bounds check, then a pixel access or a column-outer,
  // row-inner walk, then the result strobe.
  mbb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Bitmap store, address generation and the read-then-write pixel pipe.
  mbb_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .NUM_BITMAPS (NUM_BITMAPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .op_i           (op_i),
    .src_index_i    (src_index_i),
    .second_index_i (second_index_i),
    .dst_index_i    (dst_index_i),
    .src_row_i      (src_row_i),
    .src_col_i      (src_col_i),
    .dst_row_i      (dst_row_i),
    .dst_col_i      (dst_col_i),
    .rect_wid_i     (rect_wid_i),
    .rect_hgt_i     (rect_hgt_i),
    .pixel_value_i  (pixel_value_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o)
  );

endmodule
